@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked checks on clk, disabled while rst_n is low.
`ifndef SYNTHESIS
`define APR_ASSERT_NOW(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define APR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define APR_ASSERT_NOW(label, prop)
`define APR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/apr_pkg.sv @@
`default_nettype none
package apr_pkg;

    // Opcodes carried in tuser
    localparam logic [2:0] OP_TOT   = 3'd0;
    localparam logic [2:0] OP_SCAT  = 3'd1;
    localparam logic [2:0] OP_WGT   = 3'd2;
    localparam logic [2:0] OP_FLUX  = 3'd3;
    localparam logic [2:0] OP_CMP   = 3'd4;
    localparam logic [2:0] OP_EMIT  = 3'd5;

    // Multiplier operand selects for the finishing phase
    localparam logic [2:0] MS_NONE = 3'd0;
    localparam logic [2:0] MS_W    = 3'd1;
    localparam logic [2:0] MS_M    = 3'd2;
    localparam logic [2:0] MS_P00  = 3'd3;
    localparam logic [2:0] MS_P01  = 3'd4;
    localparam logic [2:0] MS_P10  = 3'd5;
    localparam logic [2:0] MS_P11  = 3'd6;

    // round(2^32 / (4*pi))
    localparam logic signed [32:0] INV4PI = 33'sd341782638;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic       ready;
        logic       accept;
        logic       do_load;
        logic       do_emit;
        logic       set_err;
        logic       rd_head;
        logic       rd_scat;
        logic [7:0] j;
        logic [2:0] mul_sel;
        logic       cap_qw;
        logic       cap_m;
        logic       cap_p_en;
        logic [1:0] cap_p_idx;
        logic       do_cmb;
        logic       do_rnd;
        logic       do_acc;
    } apr_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       cmp_err;
        logic       n_zero;
        logic [7:0] n_last;
        logic       out_full;
    } apr_stat_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? (64'd0 - 64'(x)) : 64'(x);
    endfunction

endpackage
`default_nettype wire

@@ rtl/apr_ctrl.sv @@
`default_nettype none
module apr_ctrl
    import apr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire apr_stat_t stat,
    output apr_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_LOOP  = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_W1    = 4'd4;
    localparam logic [3:0] S_W2    = 4'd5;
    localparam logic [3:0] S_W3    = 4'd6;
    localparam logic [3:0] S_W4    = 4'd7;
    localparam logic [3:0] S_PP0   = 4'd8;
    localparam logic [3:0] S_PP1   = 4'd9;
    localparam logic [3:0] S_PP2   = 4'd10;
    localparam logic [3:0] S_PP3   = 4'd11;
    localparam logic [3:0] S_PP4   = 4'd12;
    localparam logic [3:0] S_CMB   = 4'd13;
    localparam logic [3:0] S_RND   = 4'd14;
    localparam logic [3:0] S_ACC   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [7:0] j_reg, j_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
        end
    end

    // Sequencer: dispatch, scatter row walk, then finishing multiplies
    always_comb
    begin
        cmd        = '0;
        cmd.j      = j_reg;
        state_next = state_reg;
        j_next     = j_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready  = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                case (stat.op) inside
                    OP_TOT, OP_SCAT, OP_WGT, OP_FLUX:
                    begin
                        cmd.do_load = 1'b1;
                        state_next  = S_IDLE;
                    end
                    OP_CMP:
                    begin
                        if (stat.cmp_err)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                            j_next      = 8'd0;
                            state_next  = stat.n_zero ? S_DRAIN : S_LOOP;
                        end
                    end
                    OP_EMIT:
                    begin
                        if (!stat.out_full)
                        begin
                            cmd.do_emit = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_LOOP:
            begin
                cmd.rd_scat = 1'b1;
                if (j_reg == stat.n_last)
                    state_next = S_DRAIN;
                else
                    j_next = j_reg + 8'd1;
            end
            S_DRAIN: state_next = S_W1;
            S_W1:
            begin
                cmd.mul_sel = MS_W;
                state_next  = S_W2;
            end
            S_W2:
            begin
                cmd.cap_qw = 1'b1;
                state_next = S_W3;
            end
            S_W3:
            begin
                cmd.mul_sel = MS_M;
                state_next  = S_W4;
            end
            S_W4:
            begin
                cmd.cap_m  = 1'b1;
                state_next = S_PP0;
            end
            S_PP0:
            begin
                cmd.mul_sel = MS_P00;
                state_next  = S_PP1;
            end
            S_PP1:
            begin
                cmd.mul_sel   = MS_P01;
                cmd.cap_p_en  = 1'b1;
                cmd.cap_p_idx = 2'd0;
                state_next    = S_PP2;
            end
            S_PP2:
            begin
                cmd.mul_sel   = MS_P10;
                cmd.cap_p_en  = 1'b1;
                cmd.cap_p_idx = 2'd1;
                state_next    = S_PP3;
            end
            S_PP3:
            begin
                cmd.mul_sel   = MS_P11;
                cmd.cap_p_en  = 1'b1;
                cmd.cap_p_idx = 2'd2;
                state_next    = S_PP4;
            end
            S_PP4:
            begin
                cmd.cap_p_en  = 1'b1;
                cmd.cap_p_idx = 2'd3;
                state_next    = S_CMB;
            end
            S_CMB:
            begin
                cmd.do_cmb = 1'b1;
                state_next = S_RND;
            end
            S_RND:
            begin
                cmd.do_rnd = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.do_acc = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/apr_dp.sv @@
`default_nettype none
module apr_dp
    import apr_pkg::*;
#(
    parameter int GROUPS   = 32,
    parameter int MIXTURES = 16,
    parameter int ANGLES   = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire apr_cmd_t    cmd,
    output apr_stat_t        stat,
    input  wire logic [2:0]  in_op,
    input  wire logic [3:0]  in_mix,
    input  wire logic [4:0]  in_row,
    input  wire logic [4:0]  in_col,
    input  wire logic [5:0]  in_ang,
    input  wire logic [31:0] in_val,
    input  wire logic [5:0]  groups_in_use,
    input  wire logic [4:0]  group_offset,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      out_response,
    output logic             out_range_error
);

    localparam int TOT_D = MIXTURES * GROUPS;
    localparam int SCT_D = TOT_D * GROUPS;
    localparam int TAW   = addr_w(TOT_D);
    localparam int SAW   = addr_w(SCT_D);
    localparam int WAW   = addr_w(ANGLES);
    localparam int GIW   = addr_w(GROUPS);

    // Held item
    logic [2:0]         op_reg;
    logic [3:0]         mix_reg;
    logic [4:0]         row_reg, col_reg;
    logic [5:0]         ang_reg;
    logic signed [31:0] val_reg;

    // Tables
    logic signed [31:0] tot_mem  [TOT_D];
    logic signed [31:0] scat_mem [SCT_D];
    logic signed [31:0] wt_mem   [ANGLES];
    logic signed [31:0] flux_mem [GROUPS];
    logic signed [31:0] tot_q_reg, scat_q_reg, wt_q_reg, flux_q_reg;

    // Pipeline tags
    logic hv1_reg, sv1_reg, hv2_reg, sv2_reg;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod_reg;
    logic signed [63:0] dh_reg;
    logic signed [32:0] qw_reg;
    logic [63:0]        x_reg, y_reg;
    logic               neg_reg;
    logic [63:0]        p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0]        lo_reg, hi_reg;
    logic signed [63:0] term_reg;
    logic signed [63:0] sum_reg, sum_next;
    logic               err_reg, err_next;
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic               out_err_reg;

    // Index checks
    int  n_val, gx_val;
    logic mix_bad, row_bad, col_bad, ang_bad, load_bad, load_ok;
    logic [TAW-1:0] tot_waddr, tot_raddr;
    logic [SAW-1:0] scat_waddr, scat_raddr;
    logic [WAW-1:0] wt_addr;
    logic [GIW-1:0] row_idx, j_idx;

    always_comb
    begin
        mix_bad = 32'(mix_reg) >= MIXTURES;
        row_bad = 32'(row_reg) >= GROUPS;
        col_bad = 32'(col_reg) >= GROUPS;
        ang_bad = 32'(ang_reg) >= ANGLES;
        n_val   = (32'(groups_in_use) > GROUPS) ? GROUPS : 32'(groups_in_use);
        gx_val  = 32'(row_reg) + 32'(group_offset);
        case (op_reg)
            OP_TOT:  load_bad = mix_bad | row_bad;
            OP_SCAT: load_bad = mix_bad | row_bad | col_bad;
            OP_WGT:  load_bad = ang_bad;
            OP_FLUX: load_bad = row_bad;
            default: load_bad = 1'b0;
        endcase
        load_ok = cmd.do_load & ~load_bad;
        stat.op       = op_reg;
        stat.cmp_err  = mix_bad | ang_bad | row_bad | (gx_val >= GROUPS) |
                        ((n_val > 0) && (32'(group_offset) + n_val - 1 >= GROUPS));
        stat.n_zero   = (n_val == 0);
        stat.n_last   = 8'(n_val - 1);
        stat.out_full = out_valid_reg & ~out_ready;
        tot_waddr  = TAW'(32'(mix_reg) * GROUPS + 32'(row_reg));
        tot_raddr  = TAW'(32'(mix_reg) * GROUPS + gx_val);
        scat_waddr = SAW'((32'(mix_reg) * GROUPS + 32'(row_reg)) * GROUPS + 32'(col_reg));
        scat_raddr = SAW'((32'(mix_reg) * GROUPS + gx_val) * GROUPS +
                          32'(cmd.j) + 32'(group_offset));
        wt_addr    = WAW'(32'(ang_reg));
        row_idx    = GIW'(32'(row_reg));
        j_idx      = GIW'(32'(cmd.j));
    end

    // Capture accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_op;
            mix_reg <= in_mix;
            row_reg <= in_row;
            col_reg <= in_col;
            ang_reg <= in_ang;
            val_reg <= in_val;
        end
    end

    // Table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (load_ok && op_reg == OP_TOT)
            tot_mem[tot_waddr] <= val_reg;
        if (cmd.rd_head)
            tot_q_reg <= tot_mem[tot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && op_reg == OP_SCAT)
            scat_mem[scat_waddr] <= val_reg;
        if (cmd.rd_scat)
            scat_q_reg <= scat_mem[scat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && op_reg == OP_WGT)
            wt_mem[wt_addr] <= val_reg;
        if (cmd.rd_head)
            wt_q_reg <= wt_mem[wt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && op_reg == OP_FLUX)
            flux_mem[row_idx] <= val_reg;
        if (cmd.rd_head)
            flux_q_reg <= flux_mem[row_idx];
        else if (cmd.rd_scat)
            flux_q_reg <= flux_mem[j_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv1_reg <= 1'b0;
            sv1_reg <= 1'b0;
            hv2_reg <= 1'b0;
            sv2_reg <= 1'b0;
        end
        else
        begin
            hv1_reg <= cmd.rd_head;
            sv1_reg <= cmd.rd_scat;
            hv2_reg <= hv1_reg;
            sv2_reg <= sv1_reg;
        end
    end

    // Shared multiplier operand select
    logic [31:0] wmag;
    always_comb
    begin
        wmag = wt_q_reg[31] ? (32'd0 - 32'(wt_q_reg)) : 32'(wt_q_reg);
        ma = '0;
        mb = '0;
        if (hv1_reg)
        begin
            ma = {tot_q_reg[31], tot_q_reg};
            mb = {flux_q_reg[31], flux_q_reg};
        end
        else if (sv1_reg)
        begin
            ma = {scat_q_reg[31], scat_q_reg};
            mb = {flux_q_reg[31], flux_q_reg};
        end
        else
        begin
            case (cmd.mul_sel)
                MS_W:
                begin
                    ma = {1'b0, wmag};
                    mb = INV4PI;
                end
                MS_M:
                begin
                    ma = 33'sd0 - {val_reg[31], val_reg};
                    mb = qw_reg;
                end
                MS_P00:
                begin
                    ma = {1'b0, x_reg[31:0]};
                    mb = {1'b0, y_reg[31:0]};
                end
                MS_P01:
                begin
                    ma = {1'b0, x_reg[31:0]};
                    mb = {1'b0, y_reg[63:32]};
                end
                MS_P10:
                begin
                    ma = {1'b0, x_reg[63:32]};
                    mb = {1'b0, y_reg[31:0]};
                end
                MS_P11:
                begin
                    ma = {1'b0, x_reg[63:32]};
                    mb = {1'b0, y_reg[63:32]};
                end
                default:
                begin
                    ma = '0;
                    mb = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    // Operator term accumulation
    always_ff @(posedge clk)
    begin
        if (hv2_reg)
            dh_reg <= prod_reg[63:0];
        else if (sv2_reg)
            dh_reg <= sat_sub64(dh_reg, prod_reg[63:0]);
    end

    // Scaled weight, adjoint factor and partial products
    logic [63:0] qsum;
    always_comb
    begin
        qsum = 64'(prod_reg[63:0]) + 64'h8000_0000;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_qw)
            qw_reg <= wt_q_reg[31] ? (33'sd0 - $signed({1'b0, qsum[63:32]}))
                                   : $signed({1'b0, qsum[63:32]});
        if (cmd.cap_m)
        begin
            x_reg   <= mag64(dh_reg);
            y_reg   <= mag64(prod_reg[63:0]);
            neg_reg <= dh_reg[63] ^ prod_reg[63];
        end
        if (cmd.cap_p_en)
        begin
            case (cmd.cap_p_idx)
                2'd0:    p00_reg <= 64'(prod_reg[63:0]);
                2'd1:    p01_reg <= 64'(prod_reg[63:0]);
                2'd2:    p10_reg <= 64'(prod_reg[63:0]);
                default: p11_reg <= 64'(prod_reg[63:0]);
            endcase
        end
    end

    // Combine partials, then round half away and saturate
    logic [33:0] mid;
    logic [64:0] nlo;
    logic [63:0] hi2, rmag;
    logic signed [63:0] rterm;
    always_comb
    begin
        mid  = 34'(p00_reg[63:32]) + 34'(p01_reg[31:0]) + 34'(p10_reg[31:0]);
        nlo  = {1'b0, lo_reg} + 65'h8000_0000;
        hi2  = hi_reg + 64'(nlo[64]);
        rmag = {hi2[31:0], nlo[63:32]};
        if (hi2 >= 64'h8000_0000)
            rterm = neg_reg ? S64_MIN : S64_MAX;
        else if (neg_reg)
            rterm = rmag[63] ? S64_MIN : $signed(64'd0 - rmag);
        else
            rterm = rmag[63] ? S64_MAX : $signed(rmag);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_cmb)
        begin
            lo_reg <= {mid[31:0], p00_reg[31:0]};
            hi_reg <= p11_reg + 64'(p01_reg[63:32]) + 64'(p10_reg[63:32]) +
                      64'(mid[33:32]);
        end
        if (cmd.do_rnd)
            term_reg <= rterm;
    end

    // Response sum, sticky flag and output slot
    always_comb
    begin
        sum_next = sum_reg;
        err_next = err_reg;
        if (cmd.do_acc)
            sum_next = sat_add64(sum_reg, term_reg);
        if ((cmd.do_load && load_bad) || cmd.set_err)
            err_next = 1'b1;
        if (cmd.do_emit)
        begin
            sum_next = '0;
            err_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            err_reg <= err_next;
            if (cmd.do_emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_emit)
        begin
            out_data_reg <= 64'(sum_reg);
            out_err_reg  <= err_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_response    = out_data_reg;
    assign out_range_error = out_err_reg;

endmodule
`default_nettype wire

@@ rtl/adjoint_perturbation_response_top.sv @@
// Adjoint perturbation response accumulator.
// Input stream: tuser carries the opcode (load total xs, load scatter xs,
// load weight, load forward flux, compute, emit); tdata carries mixture,
// row group, column group, angle and a Q16.16 value. Output stream: one
// beat per emit with the Q32.32 saturated sum in tdata and the sticky
// range error flag in tuser.
// Each beat is dispatched before the next one is taken. In a compute beat
// the scatter row goes one element a cycle through the single shared
// multiplier, which then does the weight scaling, the adjoint factor and
// the four partial products of the final 64x64 rounding multiply.
// Emit results sit in an output register; input keeps flowing while it
// waits, and only a further emit stalls until the slot is taken.
// Reset clears the sum, the flag and the registers (group count 32,
// offset 0); tables hold garbage until loaded. Configuration goes through
// the APB port at byte addresses 0 and 4; the user must write it only
// while the block is idle, which the block itself does not enforce.
`default_nettype none
module adjoint_perturbation_response_top
    import apr_pkg::*;
#(
    parameter int GROUPS   = 32,
    parameter int MIXTURES = 16,
    parameter int ANGLES   = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // mixture[3:0], row_group[8:4], col_group[13:9], angle[19:14], value[51:20]
    input  wire logic [55:0] s_axis_tdata,
    // opcode[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // response[63:0]
    output logic [63:0]      m_axis_tdata,
    // range_error[0]
    output logic [0:0]       m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    `include "assert_macros.svh"

    localparam logic REG_GROUPS = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    logic [5:0] groups_reg;
    logic [4:0] offset_reg;
    logic       cfg_wr;
    apr_cmd_t   cmd;
    apr_stat_t  stat;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg <= 6'd32;
            offset_reg <= 5'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_GROUPS: groups_reg <= pwdata[5:0];
                REG_OFFSET: offset_reg <= pwdata[4:0];
                default:    groups_reg <= groups_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GROUPS: prdata = {26'd0, groups_reg};
            REG_OFFSET: prdata = {27'd0, offset_reg};
            default:    prdata = '0;
        endcase
    end

    apr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    apr_dp #(
        .GROUPS   (GROUPS),
        .MIXTURES (MIXTURES),
        .ANGLES   (ANGLES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_axis_tuser),
        .in_mix          (s_axis_tdata[3:0]),
        .in_row          (s_axis_tdata[8:4]),
        .in_col          (s_axis_tdata[13:9]),
        .in_ang          (s_axis_tdata[19:14]),
        .in_val          (s_axis_tdata[51:20]),
        .groups_in_use   (groups_reg),
        .group_offset    (offset_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_response    (m_axis_tdata),
        .out_range_error (m_axis_tuser[0])
    );

    assign s_axis_tready = cmd.ready;

    // One beat at a time: a taken beat is dispatched before the next
    `APR_ASSERT_NEXT(a_one_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Group count and offset only move on a register write
    `APR_ASSERT_NEXT(a_cfg_hold, !cfg_wr, $stable(groups_reg) && $stable(offset_reg))
    // An emit is never dispatched while the input side is open
    `APR_ASSERT_NOW(a_ready_ctrl, !(s_axis_tready && cmd.do_emit))

endmodule
`default_nettype wire
